// ===== rtl/gradient_threshold_adjacency_core_assert.svh =====
// assertion macros shared by the queue and back end rtl files
`ifndef GRADIENT_THRESHOLD_ADJACENCY_CORE_ASSERT_SVH
`define GRADIENT_THRESHOLD_ADJACENCY_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define GTA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gta assertion failed");
// condition must never be seen outside reset
`define GTA_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("gta forbidden condition seen");
`else
`define GTA_ASSERT(label, clk, rst, prop)
`define GTA_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== rtl/gta_pkg.sv =====
package gta_pkg;

  localparam int CNT_W         = 11;
  localparam int COORD_W       = 10;
  localparam int THR_W         = 10;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_INDEX_W   = 2;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int GRAD_W        = 14;
  localparam int MAG_W         = 12;
  localparam int SQ_W          = 2 * MAG_W + 1;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_FRAC_BITS = 8;
  localparam int MIN_DIM       = 2;

  localparam logic [THR_W-1:0] THR_RESET    = THR_W'(10);
  localparam logic [CNT_W-1:0] WIDTH_RESET  = CNT_W'(640);
  localparam logic [CNT_W-1:0] HEIGHT_RESET = CNT_W'(480);

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } cfg_reg_t;

  // back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_EMIT
  } back_state_t;

  // work handed from front to back
  typedef struct packed {
    logic                        reflect;
    logic                        inner;
    logic                        preload;
    logic                        first;
    logic                        v_ok;
    logic                        h_ok;
    logic                        last;
    logic [CNT_W-1:0]            row;
    logic [CNT_W-1:0]            col;
    logic [2:0][PIX_W-1:0]       column;
  } queue_entry_t;

  // one channel sample of a packed pixel as a signed value
  function automatic logic signed [GRAD_W-1:0] sample(input logic [PIX_W-1:0] px,
                                                      input int k);
    return $signed({{(GRAD_W-CH_W){1'b0}}, px[k*CH_W +: CH_W]});
  endfunction

endpackage

// ===== rtl/gta_if.sv =====
interface gta_pixel_if;
  import gta_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CH_W-1:0]   chan_a;
  logic [CH_W-1:0]   chan_b;
  logic [CH_W-1:0]   chan_c;
  modport source (output valid, mode, chan_a, chan_b, chan_c, input ready);
  modport sink (input valid, mode, chan_a, chan_b, chan_c, output ready);
endinterface

interface gta_result_if;
  import gta_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               vertical_adjacent;
  logic               horizontal_adjacent;
  logic               frame_last;
  modport source (output valid, out_row, out_col, vertical_adjacent, horizontal_adjacent,
                  frame_last, input ready);
  modport sink (input valid, out_row, out_col, vertical_adjacent, horizontal_adjacent,
                frame_last, output ready);
endinterface

// ===== rtl/gradient_threshold_adjacency_core.sv =====
// Scharr gradient adjacency flags for a raster stream of three-channel pixels. The
// front end takes one request per clock while the queue is not full, into a four-entry
// queue, writing the pixel into a two-row line store; the back end then reports each
// pixel one image row and one column late, so a frame of H x W pixels must be followed
// by W+1 flush requests. Requests that report nothing are popped straight from idle;
// a reported pixel holds the back end through its gradient, square, bit-serial square
// root (one unit per channel) and emit steps. Geometry writes restart the frame and
// must be made while the block is idle.
module gradient_threshold_adjacency_core
  import gta_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  gta_pixel_if.sink              pixel_in,
  gta_result_if.source           result_out
);

  logic [THR_W-1:0] threshold;
  logic [CNT_W-1:0] width_cfg;
  logic [CNT_W-1:0] height_cfg;
  logic             restart;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  queue_entry_t     push_data;
  queue_entry_t     pop_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THR_RESET;
      width_cfg  <= WIDTH_RESET;
      height_cfg <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold  <= cfg_data[THR_W-1:0];
        REG_WIDTH:     width_cfg  <= cfg_data[CNT_W-1:0];
        REG_HEIGHT:    height_cfg <= cfg_data[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  assign restart = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  gta_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel_in   (pixel_in),
    .restart    (restart),
    .width_cfg  (width_cfg),
    .height_cfg (height_cfg),
    .push       (push),
    .push_data  (push_data),
    .full       (full)
  );

  gta_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  gta_back #(.MAX_WIDTH(MAX_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .threshold  (threshold),
    .pop_data   (pop_data),
    .empty      (empty),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

// ===== rtl/gta_ram.sv =====
module gta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port, read returns the old contents on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/gta_isqrt.sv =====
module gta_isqrt
  import gta_pkg::*;
#(
  parameter int ROOT_W = 21
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root,
  output logic                  done
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W:0]     rem;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic [ROOT_W+2:0]   rem_shift;
  logic [ROOT_W+2:0]   trial;
  logic                fits;

  // one result bit per cycle
  always_comb begin
    rem_shift = {rem, rad[2*ROOT_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    fits      = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(ROOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad <= {rad[2*ROOT_W-3:0], 2'b00};
      cnt <= cnt + CW'(1);
      if (fits) begin
        rem  <= ROOT_W'(0) | (rem_shift[ROOT_W:0] - trial[ROOT_W:0]);
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[ROOT_W:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/gta_queue.sv =====
`include "gradient_threshold_adjacency_core_assert.svh"
module gta_queue
  import gta_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  queue_entry_t push_data,
  output logic         full,
  input  logic         pop,
  output queue_entry_t pop_data,
  output logic         empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  queue_entry_t    entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = count == CW'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `GTA_ASSERT_NEVER(q_no_overflow, clk, rst, push && full && !pop)
  `GTA_ASSERT_NEVER(q_no_underflow, clk, rst, pop && empty)
  `GTA_ASSERT(q_count_bound, clk, rst, count <= CW'(QUEUE_DEPTH))

endmodule

// ===== rtl/gta_front.sv =====
module gta_front
  import gta_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  gta_pixel_if.sink        pixel_in,
  input  logic             restart,
  input  logic [CNT_W-1:0] width_cfg,
  input  logic [CNT_W-1:0] height_cfg,
  output logic             push,
  output queue_entry_t     push_data,
  input  logic             full
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [CNT_W-1:0]    row;
  logic [CNT_W-1:0]    col;
  logic [CNT_W-1:0]    row_next;
  logic [CNT_W-1:0]    col_next;
  logic [CNT_W-1:0]    w;
  logic [CNT_W-1:0]    h;
  logic                drain;
  logic                accept;
  logic                go;
  logic                at_edge;
  logic [CNT_W-1:0]    p;
  logic [CNT_W-1:0]    q;
  logic [PIX_W-1:0]    pix;
  logic [AW+CNT_W-1:0] addr_ext;
  logic [AW-1:0]       addr;
  queue_entry_t        cls;

  // held item waiting for its line store data
  logic                f1_valid;
  queue_entry_t        f1_entry;
  logic [PIX_W-1:0]    f1_pix;
  logic                f1_top_pix;
  logic                f1_bot_store;
  logic                f1_slot;
  logic                f1_busy;
  logic                f1_free;
  logic [PIX_W-1:0]    slot0_q;
  logic [PIX_W-1:0]    slot1_q;
  logic [PIX_W-1:0]    st_r1;
  logic [PIX_W-1:0]    st_r2;

  // effective geometry
  always_comb begin
    if (width_cfg < CNT_W'(MIN_DIM)) begin
      w = CNT_W'(MIN_DIM);
    end else if (32'(width_cfg) > MAX_WIDTH) begin
      w = CNT_W'(MAX_WIDTH);
    end else begin
      w = width_cfg;
    end
    h = (height_cfg < CNT_W'(MIN_DIM)) ? CNT_W'(MIN_DIM) : height_cfg;
  end

  assign f1_busy        = f1_valid && (f1_entry.reflect || f1_entry.inner || f1_entry.preload);
  assign f1_free        = !f1_busy || !full;
  assign pixel_in.ready = f1_free;
  assign accept         = pixel_in.valid && f1_free;
  assign drain          = row >= h;
  assign go             = accept && (drain || !pixel_in.mode);
  assign pix            = {pixel_in.chan_c, pixel_in.chan_b, pixel_in.chan_a};
  assign addr_ext       = {{AW{1'b0}}, col};
  assign addr           = addr_ext[AW-1:0];

  // classify the slot
  always_comb begin
    at_edge     = col == '0 || col >= w;
    cls         = '0;
    cls.reflect = at_edge && (col != '0 || row >= CNT_W'(2));
    cls.preload = at_edge && col == '0 && row >= CNT_W'(1);
    cls.inner   = !at_edge && row >= CNT_W'(1);
    cls.first   = col == CNT_W'(1);
    if (cls.reflect) begin
      p = (col == '0) ? row - CNT_W'(2) : row - CNT_W'(1);
      q = w - CNT_W'(1);
    end else begin
      p = row - CNT_W'(1);
      q = col - CNT_W'(1);
    end
    cls.row  = p;
    cls.col  = q;
    cls.v_ok = p >= CNT_W'(1);
    cls.h_ok = p >= CNT_W'(1) && q >= CNT_W'(1);
    cls.last = p == h - CNT_W'(1) && q == w - CNT_W'(1);
  end

  // stream position
  always_comb begin
    row_next = row;
    col_next = col;
    if (!drain) begin
      if (col + CNT_W'(1) >= w) begin
        col_next = '0;
        row_next = row + CNT_W'(1);
      end else begin
        col_next = col + CNT_W'(1);
      end
    end else if (col >= w) begin
      row_next = '0;
      col_next = '0;
    end else begin
      col_next = col + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row <= '0;
      col <= '0;
    end else if (go) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // line store, one memory per row parity
  gta_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_slot0 (
    .clk     (clk),
    .wr_en   (go && !drain && !row[0]),
    .wr_addr (addr),
    .wr_data (pix),
    .rd_en   (go && col < w),
    .rd_addr (addr),
    .rd_data (slot0_q)
  );

  gta_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_slot1 (
    .clk     (clk),
    .wr_en   (go && !drain && row[0]),
    .wr_addr (addr),
    .wr_data (pix),
    .rd_en   (go && col < w),
    .rd_addr (addr),
    .rd_data (slot1_q)
  );

  // hold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (accept) begin
      f1_valid <= go;
    end else if (f1_free) begin
      f1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      f1_entry     <= cls;
      f1_pix       <= pix;
      f1_top_pix   <= row == CNT_W'(1);
      f1_bot_store <= drain;
      f1_slot      <= row[0];
    end
  end

  // assemble the column from store and incoming pixel
  always_comb begin
    st_r2     = f1_slot ? slot1_q : slot0_q;
    st_r1     = f1_slot ? slot0_q : slot1_q;
    push_data = f1_entry;
    push_data.column[0] = f1_top_pix ? f1_pix : st_r2;
    push_data.column[1] = st_r1;
    push_data.column[2] = f1_bot_store ? st_r2 : f1_pix;
  end

  assign push = f1_busy && !full;

endmodule

// ===== rtl/gta_back.sv =====
`include "gradient_threshold_adjacency_core_assert.svh"
module gta_back
  import gta_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [THR_W-1:0] threshold,
  input  queue_entry_t     pop_data,
  input  logic             empty,
  output logic             pop,
  gta_result_if.source     result_out
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int ROOT_W = (SQ_W + 2 * FRAC_BITS + 1) / 2;
  localparam int SUM_W  = ROOT_W + 2;
  localparam int LIM_W  = THR_W + 5 + FRAC_BITS;
  localparam int CMP_W  = (SUM_W > LIM_W) ? SUM_W : LIM_W;

  back_state_t state;
  back_state_t state_next;

  logic [2:0][2:0][PIX_W-1:0] win;
  logic [2:0][2:0][PIX_W-1:0] win_next;
  queue_entry_t               cur;
  logic [2:0][MAG_W-1:0]      ax;
  logic [2:0][MAG_W-1:0]      ay;
  logic [2:0][MAG_W-1:0]      ax_next;
  logic [2:0][MAG_W-1:0]      ay_next;
  logic [2:0][2*ROOT_W-1:0]   radicand;
  logic [2:0][ROOT_W-1:0]     root;
  logic [2:0]                 root_done;
  logic                       sqrt_start;
  logic [CMP_W-1:0]           mag_sum;
  logic [CMP_W-1:0]           limit;
  logic                       below;
  logic                       left_flag;
  logic                       above_flag;
  logic                       load;
  logic                       emits;
  logic [AW+CNT_W-1:0]        q_ext;
  logic [AW-1:0]              q_addr;
  logic [AW+CNT_W-1:0]        cq_ext;
  logic [AW-1:0]              cur_addr;

  logic                       out_valid;
  logic [COORD_W-1:0]         out_row;
  logic [COORD_W-1:0]         out_col;
  logic                       out_vert;
  logic                       out_horz;
  logic                       out_last;

  assign emits    = pop_data.reflect || pop_data.inner;
  assign q_ext    = {{AW{1'b0}}, pop_data.col};
  assign q_addr   = q_ext[AW-1:0];
  assign cq_ext   = {{AW{1'b0}}, cur.col};
  assign cur_addr = cq_ext[AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (!empty && emits) state_next = ST_GRAD;
      ST_GRAD:   state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_ROOT;
      ST_ROOT:   if (root_done[0]) state_next = ST_EMIT;
      ST_EMIT:   if (!out_valid || result_out.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop        = 1'b0;
    sqrt_start = 1'b0;
    load       = 1'b0;
    unique case (state)
      ST_IDLE:   pop = !empty;
      ST_GRAD:   ;
      ST_SQUARE: sqrt_start = 1'b1;
      ST_ROOT:   ;
      ST_EMIT:   load = !out_valid || result_out.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // window update for the popped entry
  always_comb begin
    win_next = win;
    if (pop_data.reflect) begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = win[1];
    end
    if (pop_data.inner) begin
      win_next[0] = pop_data.first ? pop_data.column : win[1];
      win_next[1] = win[2];
      win_next[2] = pop_data.column;
    end else if (pop_data.preload) begin
      win_next[2] = pop_data.column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (pop) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // scharr kernels per channel, a reflected right column mirrors the left one
  always_comb begin
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] gxa;
    logic signed [GRAD_W-1:0] gya;
    logic [2:0][PIX_W-1:0]    rc;
    rc = cur.reflect ? win[0] : win[2];
    for (int k = 0; k < 3; k++) begin
      gx = GRAD_W'(3)  * (sample(rc[0], k) - sample(win[0][0], k))
         + GRAD_W'(10) * (sample(rc[1], k) - sample(win[0][1], k))
         + GRAD_W'(3)  * (sample(rc[2], k) - sample(win[0][2], k));
      gy = GRAD_W'(3)  * (sample(win[0][2], k) - sample(win[0][0], k))
         + GRAD_W'(10) * (sample(win[1][2], k) - sample(win[1][0], k))
         + GRAD_W'(3)  * (sample(rc[2], k) - sample(rc[0], k));
      gxa = (gx < 0) ? -gx : gx;
      gya = (gy < 0) ? -gy : gy;
      ax_next[k] = gxa[MAG_W-1:0];
      ay_next[k] = gya[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_GRAD) begin
      ax <= ax_next;
      ay <= ay_next;
    end
  end

  // squared magnitude scaled to fixed point, registered inside the root unit
  always_comb begin
    logic [SQ_W-1:0] sq;
    for (int k = 0; k < 3; k++) begin
      sq = SQ_W'(ax[k] * ax[k]) + SQ_W'(ay[k] * ay[k]);
      radicand[k] = (2*ROOT_W)'(sq) << (2 * FRAC_BITS);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_root
    gta_isqrt #(.ROOT_W(ROOT_W)) u_isqrt (
      .clk      (clk),
      .rst      (rst),
      .start    (sqrt_start),
      .radicand (radicand[k]),
      .root     (root[k]),
      .done     (root_done[k])
    );
  end

  // sum of magnitudes against the threshold
  assign mag_sum = CMP_W'(root[0]) + CMP_W'(root[1]) + CMP_W'(root[2]);
  assign limit   = CMP_W'(threshold) << (5 + FRAC_BITS);

  always_ff @(posedge clk) begin
    if (state == ST_ROOT && root_done[0]) begin
      below <= mag_sum < limit;
    end
  end

  // below flags of the previous row
  gta_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flag_row (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (cur_addr),
    .wr_data (below),
    .rd_en   (pop && emits),
    .rd_addr (q_addr),
    .rd_data (above_flag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_flag <= 1'b0;
    end else if (load) begin
      left_flag <= below;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row  <= cur.row[COORD_W-1:0];
      out_col  <= cur.col[COORD_W-1:0];
      out_vert <= cur.v_ok && above_flag;
      out_horz <= cur.h_ok && left_flag;
      out_last <= cur.last;
    end
  end

  assign result_out.valid               = out_valid;
  assign result_out.out_row             = out_row;
  assign result_out.out_col             = out_col;
  assign result_out.vertical_adjacent   = out_vert;
  assign result_out.horizontal_adjacent = out_horz;
  assign result_out.frame_last          = out_last;

  `GTA_ASSERT(b_done_in_root, clk, rst, root_done[0] |-> state == ST_ROOT)
  `GTA_ASSERT(b_load_returns_idle, clk, rst, load |=> state == ST_IDLE && out_valid)
  `GTA_ASSERT(b_roots_together, clk, rst, root_done[0] == root_done[1] &&
                                          root_done[1] == root_done[2])

endmodule

// ===== dv/gradient_threshold_adjacency_core_tb.sv =====
module gradient_threshold_adjacency_core_tb;
  import gta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT = 4000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  // pixel content styles
  typedef enum int { PIX_NOISE, PIX_SMOOTH, PIX_EXTREME } pix_style_t;
  typedef enum logic { MODE_PIXEL = 1'b0, MODE_FLUSH = 1'b1 } req_mode_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               vert;
    logic               horiz;
    logic               last;
  } adj_flags_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gta_pixel_if pix();
  gta_result_if res();

  gradient_threshold_adjacency_core uut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel_in(pix), .result_out(res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [PIX_W-1:0] line_store [2*LINE_MAX];
  logic [PIX_W-1:0] window [9];
  logic below_row [LINE_MAX];
  logic left_below;
  int unsigned row_cnt, col_cnt;
  int unsigned thr_reg, width_reg, height_reg;

  adj_flags_t expected_flags [$];
  int error_count = 0;
  bit quiet_phase = 0;
  int unsigned stall_cnt = 0;

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned eff_width();
    if (width_reg < MIN_DIM) return MIN_DIM;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic int chan(input logic [PIX_W-1:0] p, input int k);
    return int'(p[k*CH_W +: CH_W]);
  endfunction

  function automatic logic [PIX_W-1:0] line_at(input int unsigned r, input int unsigned c);
    return line_store[(r & 1) * LINE_MAX + (c % LINE_MAX)];
  endfunction

  // column of rows tr-1, tr, tr+1 with reflected borders
  task automatic fetch_col(input int unsigned tr, input int unsigned c,
                           input logic [PIX_W-1:0] p, input int unsigned h,
                           output logic [PIX_W-1:0] d [3]);
    d[0] = (tr == 0) ? p : line_at(tr - 1, c);
    d[1] = line_at(tr, c);
    d[2] = (tr + 1 >= h) ? line_at(tr - 1, c) : p;
  endtask

  task automatic shift_window(input logic [PIX_W-1:0] d [3]);
    for (int i = 0; i < 3; i++) begin
      window[i] = window[3+i];
      window[3+i] = window[6+i];
      window[6+i] = d[i];
    end
  endtask

  // gradient magnitude sum of the window and flag lookup
  task automatic flag_pixel(input int unsigned p, input int unsigned q,
                            input int unsigned h, input int unsigned w);
    longint unsigned sum = 0;
    longint unsigned lim = longint'(thr_reg) << (5 + DEF_FRAC_BITS);
    adj_flags_t f;
    logic blw;
    int gx, gy;
    longint unsigned ax, ay;
    for (int k = 0; k < 3; k++) begin
      gx = 3 * (chan(window[6], k) - chan(window[0], k))
         + 10 * (chan(window[7], k) - chan(window[1], k))
         + 3 * (chan(window[8], k) - chan(window[2], k));
      gy = 3 * (chan(window[2], k) - chan(window[0], k))
         + 10 * (chan(window[5], k) - chan(window[3], k))
         + 3 * (chan(window[8], k) - chan(window[6], k));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      sum += int_sqrt((ax * ax + ay * ay) << (2 * DEF_FRAC_BITS));
    end
    blw = (sum < lim);
    f.row = p[COORD_W-1:0];
    f.col = q[COORD_W-1:0];
    f.vert = (p >= 1) ? below_row[q % LINE_MAX] : 1'b0;
    f.horiz = (p >= 1 && q >= 1) ? left_below : 1'b0;
    f.last = (p == h - 1 && q == w - 1);
    below_row[q % LINE_MAX] = blw;
    left_below = blw;
    expected_flags.push_back(f);
  endtask

  // advance the predictor by one accepted request
  task automatic predict_request(input req_mode_t m, input logic [PIX_W-1:0] p);
    int unsigned h = eff_height();
    int unsigned w = eff_width();
    int unsigned r = row_cnt;
    int unsigned c = col_cnt;
    bit drain = (r >= h);
    logic [PIX_W-1:0] d [3];
    if (!drain && m == MODE_FLUSH) return;
    if (c == 0 || c >= w) begin
      if (c != 0 || r >= 2) begin
        d[0] = window[3];
        d[1] = window[4];
        d[2] = window[5];
        shift_window(d);
        flag_pixel((c == 0) ? r - 2 : r - 1, w - 1, h, w);
      end
      if (c == 0 && r >= 1) begin
        fetch_col(r - 1, 0, p, h, d);
        for (int i = 0; i < 3; i++) window[6+i] = d[i];
      end
    end else if (r >= 1) begin
      fetch_col(r - 1, c, p, h, d);
      shift_window(d);
      if (c == 1) for (int i = 0; i < 3; i++) window[i] = d[i];
      flag_pixel(r - 1, c - 1, h, w);
    end
    if (!drain) begin
      line_store[(r & 1) * LINE_MAX + (c % LINE_MAX)] = p;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
    end else if (c >= w) begin
      r = 0;
      c = 0;
    end else begin
      c++;
    end
    row_cnt = r & 11'h7FF;
    col_cnt = c & 11'h7FF;
  endtask

  // one request on the pixel channel; valid stays high on return
  task automatic send_request(input req_mode_t m, input logic [PIX_W-1:0] p);
    int unsigned gap = quiet_phase ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.mode <= m;
    pix.chan_a <= p[7:0];
    pix.chan_b <= p[15:8];
    pix.chan_c <= p[23:16];
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    predict_request(m, p);
  endtask

  // stop sending and let every pending flag result drain
  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (expected_flags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_THRESHOLD) begin
      thr_reg = val & 10'h3FF;
    end else if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
      if (idx == REG_WIDTH) width_reg = val & 11'h7FF;
      else height_reg = val & 11'h7FF;
      row_cnt = 0;
      col_cnt = 0;
    end
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(input pix_style_t s);
    logic [PIX_W-1:0] p;
    case (s)
      PIX_SMOOTH: p = {8'(120 + $urandom_range(0, 3)), 8'(60 + $urandom_range(0, 2)),
                       8'(200 + $urandom_range(0, 4))};
      PIX_EXTREME: p = {($urandom_range(0, 1) ? 8'hFF : 8'h00),
                        ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                        ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      default: p = 24'($urandom);
    endcase
    return p;
  endfunction

  // one frame of pixels plus its drain, optionally with stray flush requests
  task automatic run_frame(input pix_style_t s, input bit noisy, input int unsigned rows);
    int unsigned w = eff_width();
    for (int unsigned i = 0; i < rows * w; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) send_request(MODE_FLUSH, 24'($urandom));
      send_request(MODE_PIXEL, make_pixel(s));
    end
    for (int unsigned i = 0; i <= w; i++)
      send_request(req_mode_t'($urandom_range(0, 1)), 24'($urandom));
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // threshold extremes on flat, noisy and saturated content
  task automatic test_threshold_extremes();
    set_geometry(4, 3);
    write_reg(REG_THRESHOLD, 0);
    run_frame(PIX_NOISE, 0, 3);
    write_reg(REG_THRESHOLD, 1023);
    run_frame(PIX_EXTREME, 0, 3);
    write_reg(REG_THRESHOLD, 5);
    run_frame(PIX_SMOOTH, 1, 3);
  endtask

  // smallest geometry and out of range register values
  task automatic test_geometry_clamp();
    write_reg(REG_THRESHOLD, 300);
    set_geometry(0, 1);
    run_frame(PIX_NOISE, 1, 2);
    write_reg(REG_UNUSED, 11'h7FF);
    set_geometry(2, 2);
    run_frame(PIX_EXTREME, 0, 2);
  endtask

  // geometry write in the middle of a frame restarts it
  task automatic test_restart();
    set_geometry(5, 4);
    for (int i = 0; i < 9; i++) send_request(MODE_PIXEL, make_pixel(PIX_NOISE));
    write_reg(REG_WIDTH, 5);
    run_frame(PIX_NOISE, 0, 4);
  endtask

  task automatic test_random_frames();
    int unsigned sent = 0;
    int unsigned w, h;
    while (sent < 400) begin
      w = $urandom_range(2, 8);
      h = $urandom_range(2, 6);
      quiet_phase = ($urandom_range(0, 3) == 0);
      write_reg(REG_THRESHOLD, $urandom_range(0, 1023) >> $urandom_range(0, 5));
      set_geometry(w, h);
      run_frame(pix_style_t'($urandom_range(0, 2)), $urandom_range(0, 1), h);
      sent += (h + 1) * w + 1;
    end
    quiet_phase = 0;
  endtask

  // result side: ready stalls and comparison
  always @(posedge clk) begin
    adj_flags_t want;
    logic rdy;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (expected_flags.size() == 0) begin
          report("unexpected result row", res.out_row, 0);
        end else begin
          want = expected_flags.pop_front();
          if (res.out_row !== want.row) report("out_row", res.out_row, want.row);
          if (res.out_col !== want.col) report("out_col", res.out_col, want.col);
          if (res.vertical_adjacent !== want.vert)
            report("vertical_adjacent", res.vertical_adjacent, want.vert);
          if (res.horizontal_adjacent !== want.horiz)
            report("horizontal_adjacent", res.horizontal_adjacent, want.horiz);
          if (res.frame_last !== want.last) report("frame_last", res.frame_last, want.last);
        end
        stall_cnt = quiet_phase ? 0 : $urandom_range(0, 11);
      end
      rdy = (stall_cnt == 0);
      if (stall_cnt > 0) stall_cnt--;
      res.ready <= rdy;
    end
  end

  // watchdog on cycles with no handshake on either side
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    pix.valid = 1'b0;
    pix.mode = MODE_PIXEL;
    pix.chan_a = '0;
    pix.chan_b = '0;
    pix.chan_c = '0;
    res.ready = 1'b0;
    thr_reg = THR_RESET;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    for (int i = 0; i < 2 * LINE_MAX; i++) line_store[i] = '0;
    for (int i = 0; i < 9; i++) window[i] = '0;
    for (int i = 0; i < LINE_MAX; i++) below_row[i] = 1'b0;
    left_below = 1'b0;
    row_cnt = 0;
    col_cnt = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_threshold_extremes();
    test_geometry_clamp();
    test_restart();
    test_random_frames();
    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
